[design/assert_macros.svh]
// Assertion macros shared by the checker files of the frame pacer.
// Depends on a clock named clk and a synchronous reset named rst in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked outside reset only.
`define VFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define VFP_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/vfp_pkg.sv]
// Types and constants of the vsync frame pacer.
// No dependencies; every other design file but assert_macros.svh imports this package.
package vfp_pkg;

  localparam int TS_W     = 63;  // vsync timestamp width
  localparam int PERIOD_W = 27;  // period estimate width
  localparam int CFG_W    = 20;  // minimum frame time register width
  localparam int LIMIT_W  = 30;  // limit in nanoseconds, CFG_W bits times 1000
  localparam int DL_W     = 64;  // deadline width
  localparam int AVG_W    = 30;  // width of 7*old + delta
  localparam int ADDR_W   = 3;   // APB byte address width
  localparam int DATA_W   = 32;  // APB data width

  localparam logic [DL_W-1:0]    DELTA_LOW  = DL_W'(4000000);
  localparam logic [DL_W-1:0]    DELTA_HIGH = DL_W'(100000000);
  localparam logic [LIMIT_W-1:0] US_TO_NS   = LIMIT_W'(1000);

  // Register index, selected by paddr[2].
  localparam logic REG_MIN_FRAME = 1'b0;

  typedef logic [TS_W-1:0]     ts_t;
  typedef logic [PERIOD_W-1:0] period_t;
  typedef logic [CFG_W-1:0]    cfg_word_t;
  typedef logic [LIMIT_W-1:0]  limit_t;
  typedef logic [DL_W-1:0]     deadline_t;

  // Configuration handed from the register block to the core.
  typedef struct packed {
    limit_t limit_ns;
  } vfp_cfg_t;

endpackage

[design/vfp_if.sv]
// Valid/ready channel interfaces of the vsync frame pacer.
// Depends on vfp_pkg for the payload types.
interface vfp_in_if;
  import vfp_pkg::*;

  logic valid;
  logic ready;
  ts_t  vsync_time_ns;

  modport source (output valid, output vsync_time_ns, input ready);
  modport sink   (input valid, input vsync_time_ns, output ready);
endinterface

interface vfp_out_if;
  import vfp_pkg::*;

  logic    valid;
  logic    ready;
  logic    render_now;
  period_t period_estimate_ns;

  modport source (output valid, output render_now, output period_estimate_ns, input ready);
  modport sink   (input valid, input render_now, input period_estimate_ns, output ready);
endinterface

[design/vsync_frame_pacer_unit.sv]
// Top level of the vsync frame pacer.
// Depends on vfp_pkg, vfp_if.sv, vfp_cfg_regs and vfp_core.
// Usage:
//   The vsync channel carries one word per display vsync: its timestamp in
//   nanoseconds. The pace channel returns one word per vsync word, in order:
//   render_now says whether to draw a frame on this vsync, and
//   period_estimate_ns is the averaged refresh period after this vsync.
//   The APB port holds one register, min_frame_time_us at byte address 0.
//   Write it only while no vsync word is in flight.
// Timing:
//   An accepted word moves from the input register to the result register once
//   that is empty or its result is taken. A new word can be taken every cycle
//   while the receiver takes results; the period, deadline and last timestamp
//   state is updated in one pass as a word enters the result register.
// Reset and stalls:
//   Reset (rst, synchronous) empties both stages, clears the period
//   estimate and last timestamp, drops any deadline and sets the register
//   to zero. If the receiver holds ready low, the result register keeps its
//   word, one more word waits in the input register, and then vsync.ready
//   goes low until the result is taken.
module vsync_frame_pacer_unit (
  input  logic                       clk,
  input  logic                       rst,
  vfp_in_if.sink                     vsync,
  vfp_out_if.source                  pace,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [vfp_pkg::ADDR_W-1:0] paddr,
  input  logic [vfp_pkg::DATA_W-1:0] pwdata,
  output logic [vfp_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import vfp_pkg::*;

  vfp_cfg_t cfg;

  // Writes always complete in their access cycle.
  assign pready = 1'b1;

  vfp_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  vfp_core u_core (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .vsync (vsync),
    .pace  (pace)
  );
endmodule

[design/vfp_cfg_regs.sv]
// APB register block of the frame pacer: the minimum frame time register.
// Depends on vfp_pkg; precomputes the limit in nanoseconds for the core.
module vfp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vfp_pkg::ADDR_W-1:0]    paddr,
  input  logic [vfp_pkg::DATA_W-1:0]    pwdata,
  output logic [vfp_pkg::DATA_W-1:0]    prdata,
  output vfp_pkg::vfp_cfg_t             cfg
);
  import vfp_pkg::*;

  cfg_word_t min_frame_time_us;
  limit_t    limit_ns;
  logic      wr_en;

  assign wr_en = psel && penable && pwrite && (paddr[2] == REG_MIN_FRAME);

  // The multiply by 1000 happens once per write, off the item path.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_frame_time_us <= '0;
      limit_ns          <= '0;
    end else if (wr_en) begin
      min_frame_time_us <= pwdata[CFG_W-1:0];
      limit_ns          <= LIMIT_W'(pwdata[CFG_W-1:0]) * US_TO_NS;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MIN_FRAME) begin
      prdata = DATA_W'(min_frame_time_us);
    end
  end

  assign cfg.limit_ns = limit_ns;
endmodule

[design/vfp_core.sv]
// Pacing core: input register, period and deadline state, result register.
// Depends on vfp_pkg and the channel interfaces in vfp_if.sv.
module vfp_core (
  input  logic              clk,
  input  logic              rst,
  input  vfp_pkg::vfp_cfg_t cfg,
  vfp_in_if.sink            vsync,
  vfp_out_if.source         pace
);
  import vfp_pkg::*;

  // Input stage
  logic s1_valid;
  ts_t  t_q;
  logic s1_move;

  // Pacer state
  ts_t       last_vsync;
  period_t   period_avg;
  deadline_t deadline;
  logic      deadline_valid;

  // Result stage
  logic    out_valid;
  logic    render_q;
  period_t period_q;

  // Combinational pass
  deadline_t t_ext;
  deadline_t delta;
  logic      delta_ok;
  logic [AVG_W-1:0] avg_sum;
  period_t   period_next;
  logic [PERIOD_W:0] off_thresh;
  logic      limit_on;
  deadline_t t_slack;
  logic      skip;
  logic      advance;
  deadline_t deadline_next;
  logic      deadline_valid_next;

  assign s1_move     = s1_valid && (!out_valid || pace.ready);
  assign vsync.ready = !s1_valid || s1_move;

  always_comb begin
    t_ext = {1'b0, t_q};
    delta = t_ext - {1'b0, last_vsync};

    // Only a forward step strictly inside the 4 ms to 100 ms window counts.
    delta_ok = (last_vsync != '0) && (t_q > last_vsync) &&
               (delta > DELTA_LOW) && (delta < DELTA_HIGH);

    avg_sum = {period_avg, 3'b000} - AVG_W'(period_avg) + AVG_W'(delta[PERIOD_W-1:0]);

    period_next = period_avg;
    if (delta_ok) begin
      if (period_avg == '0) begin
        period_next = delta[PERIOD_W-1:0];
      end else begin
        period_next = avg_sum[PERIOD_W+2:3];
      end
    end

    // Limiting is off when the limit is within 1.125 periods.
    off_thresh = {1'b0, period_next} + (PERIOD_W+1)'(period_next >> 3);
    limit_on   = (cfg.limit_ns != '0) &&
                 ((period_next == '0) || (LIMIT_W'(off_thresh) < cfg.limit_ns));

    t_slack = t_ext + DL_W'(period_next >> 1);
    skip    = limit_on && deadline_valid && (t_slack < deadline);

    advance = deadline_valid &&
              ((t_ext < deadline) || ((t_ext - deadline) < DL_W'(cfg.limit_ns)));

    deadline_next       = deadline;
    deadline_valid_next = deadline_valid;
    if (!limit_on) begin
      deadline_valid_next = 1'b0;
    end else if (!skip) begin
      deadline_valid_next = 1'b1;
      if (advance) begin
        deadline_next = deadline + DL_W'(cfg.limit_ns);
      end else begin
        deadline_next = t_ext + DL_W'(cfg.limit_ns);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      last_vsync     <= '0;
      period_avg     <= '0;
      deadline_valid <= 1'b0;
    end else begin
      if (vsync.valid && vsync.ready) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end

      if (s1_move) begin
        out_valid      <= 1'b1;
        last_vsync     <= t_q;
        period_avg     <= period_next;
        deadline_valid <= deadline_valid_next;
      end else if (pace.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vsync.valid && vsync.ready) begin
      t_q <= vsync.vsync_time_ns;
    end
    if (s1_move) begin
      deadline <= deadline_next;
      render_q <= !skip;
      period_q <= period_next;
    end
  end

  assign pace.valid              = out_valid;
  assign pace.render_now         = render_q;
  assign pace.period_estimate_ns = period_q;
endmodule

[design/vfp_checker.sv]
// Port-level checks of the vsync frame pacer, bound to the top level.
// Depends on vfp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vfp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         render_now,
  input logic [vfp_pkg::PERIOD_W-1:0] period_estimate_ns
);
  import vfp_pkg::*;

  // A result held back by the receiver keeps its word.
  `VFP_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(render_now) && $stable(period_estimate_ns)), "stalled result changed")

  // Reset empties the result stage.
  `VFP_ASSERT_ALL(a_rst_empty, rst |=> !out_valid, "result valid after reset")

  // Only deltas under 100 ms enter the estimate.
  `VFP_ASSERT(a_period_range, out_valid |-> (period_estimate_ns < PERIOD_W'(100000000)), "period estimate out of range")

  // A result appearing on an empty output comes from a word that passed the input register without waiting.
  `VFP_ASSERT(a_rise_source, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without input word")
endmodule

bind vsync_frame_pacer_unit vfp_checker u_vfp_checker (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (vsync.valid),
  .in_ready           (vsync.ready),
  .out_valid          (pace.valid),
  .out_ready          (pace.ready),
  .render_now         (pace.render_now),
  .period_estimate_ns (pace.period_estimate_ns)
);

[tb/tb_top.sv]
// Self-checking testbench of vsync_frame_pacer_unit: vsync words in, pace words out.
// Depends on vfp_pkg and the channel interfaces of design/vfp_if.sv; predicts each
// pace word in the bench and drives the min_frame_time_us register over APB.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import vfp_pkg::*;

  // The slowest correct run stays far below this limit.
  localparam int CYCLE_LIMIT  = 400_000;
  // Wait before the final check, after the owed pace words have drained.
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_PHASES = 11;
  localparam int PHASE_WORDS   = 100;

  localparam logic [63:0]       TS_MAX         = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam cfg_word_t         CFG_MAX        = '1;
  localparam logic [ADDR_W-1:0] MIN_FRAME_ADDR = {REG_MIN_FRAME, 2'b00};

  // One pace word as the block returns it.
  typedef struct packed {
    logic    render_now;
    period_t period_estimate_ns;
  } pace_word_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  vfp_in_if  vsync_ch ();
  vfp_out_if pace_ch ();

  vsync_frame_pacer_unit dut (
    .clk     (clk),
    .rst     (rst),
    .vsync   (vsync_ch),
    .pace    (pace_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Bench copy of the pacer state and of its one register.
  ts_t       last_stamp;
  period_t   period_est;
  logic [63:0] deadline_ns;
  logic      deadline_live;
  cfg_word_t min_frame_us;

  // Pace words still owed by the block, oldest first.
  pace_word_t pending_pace[$];

  // Control of both sides of the stream.
  bit sender_idles;
  bit receiver_idles;
  int hold_off_left;

  int fail_count;
  int words_sent;
  int words_checked;
  int skips_seen;
  int settings_written;
  int cycle_count;

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  // Works out the pace word for one vsync timestamp and moves the bench state
  // on, just as the block must when it takes the word.
  function automatic pace_word_t pace_decision(input ts_t stamp);
    logic [63:0] t;
    logic [63:0] delta;
    logic [63:0] avg;
    logic [63:0] limit;
    logic [63:0] slack;
    pace_word_t  w;
    t = {1'b0, stamp};
    w.render_now = 1'b1;
    // A zero last timestamp means none; backward steps give no delta at all.
    if (last_stamp != '0 && stamp > last_stamp) begin
      delta = t - {1'b0, last_stamp};
      if (delta > DELTA_LOW && delta < DELTA_HIGH) begin
        if (period_est == '0) begin
          avg = delta;
        end else begin
          avg = (64'(period_est) * 7 + delta) / 8;
        end
        period_est = avg[PERIOD_W-1:0];
      end
    end
    last_stamp = stamp;

    // Limits up to 1.125 periods of a known refresh turn pacing off.
    limit = 64'(min_frame_us) * 1000;
    if (limit != 0 && period_est != '0 &&
        limit <= 64'(period_est) + 64'(period_est) / 8) begin
      limit = '0;
    end
    slack = 64'(period_est) / 2;

    if (limit != 0 && deadline_live && t + slack < deadline_ns) begin
      w.render_now = 1'b0;
    end else if (limit != 0) begin
      // On time, or late by less than one limit: keep the cadence.
      if (deadline_live && (t < deadline_ns || t - deadline_ns < limit)) begin
        deadline_ns = deadline_ns + limit;
      end else begin
        deadline_ns = t + limit;
      end
      deadline_live = 1'b1;
    end else begin
      deadline_ns   = '0;
      deadline_live = 1'b0;
    end
    w.period_estimate_ns = period_est;
    return w;
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("[%0d] ERROR: %s", cycle_count, what);
    end
  endtask

  // One APB transfer: setup cycle, then access until pready. Called at a clock edge.
  // psel stays high afterwards so that a second transfer can follow; the caller
  // ends the sequence.
  task automatic apb_transfer(input logic wr, input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= MIN_FRAME_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
  endtask

  // Writes min_frame_time_us and reads it back. Only called with nothing in flight.
  task automatic set_min_frame(input cfg_word_t value);
    logic [DATA_W-1:0] unused;
    logic [DATA_W-1:0] readback;
    apb_transfer(1'b1, DATA_W'(value), unused);
    min_frame_us = value;
    settings_written++;
    apb_transfer(1'b0, '0, readback);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[CFG_W-1:0] !== value) begin
      note_failure($sformatf("min_frame_time_us reads %0d, expected %0d",
                             readback[CFG_W-1:0], value));
    end
  endtask

  // Offers one vsync word and returns at the edge that takes it. valid stays
  // high so that a following word can go out back to back.
  task automatic send_vsync(input ts_t stamp);
    while (sender_idles && $urandom_range(99) < 24) begin
      vsync_ch.valid <= 1'b0;
      @(posedge clk);
    end
    vsync_ch.valid         <= 1'b1;
    vsync_ch.vsync_time_ns <= stamp;
    @(posedge clk);
    while (!vsync_ch.ready) @(posedge clk);
  endtask

  // The sender goes quiet and waits for every owed pace word. The first edge
  // lets the prediction of the last accepted word land in the queue.
  task automatic drain_pace;
    vsync_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pace.size() != 0) @(posedge clk);
  endtask

  // Before any refresh period is known the limit always applies; then the period
  // is seeded at exactly 8 ms and every later delta keeps it there. A late vsync
  // restarts the deadline instead of advancing it.
  task automatic test_unknown_period_pacing;
    set_min_frame(cfg_word_t'(20_000));
    send_vsync(ts_t'(0));
    send_vsync(ts_t'(8_000_000));
    send_vsync(ts_t'(16_000_000));
    for (int i = 3; i <= 6; i++) begin
      send_vsync(ts_t'(i * 8_000_000));
    end
    send_vsync(ts_t'(248_000_000));
    send_vsync(ts_t'(256_000_000));
    send_vsync(ts_t'(264_000_000));
    drain_pace();
  endtask

  // With an 8 ms period, 9 ms is exactly 1.125 periods: pacing is off there and
  // on one microsecond above it.
  task automatic test_limit_threshold;
    set_min_frame(cfg_word_t'(9_000));
    send_vsync(ts_t'(272_000_000));
    send_vsync(ts_t'(280_000_000));
    drain_pace();
    set_min_frame(cfg_word_t'(9_001));
    send_vsync(ts_t'(288_000_000));
    send_vsync(ts_t'(296_000_000));
    send_vsync(ts_t'(304_000_000));
    drain_pace();
  endtask

  // Deltas at and next to both ends of the window, a step backward, a repeated
  // timestamp, and a zero timestamp that hides the following delta.
  task automatic test_delta_window;
    set_min_frame('0);
    send_vsync(ts_t'(308_000_000));
    send_vsync(ts_t'(312_000_001));
    send_vsync(ts_t'(412_000_001));
    send_vsync(ts_t'(512_000_000));
    send_vsync(ts_t'(507_000_000));
    send_vsync(ts_t'(507_000_000));
    send_vsync(ts_t'(0));
    send_vsync(ts_t'(8_000_000));
    drain_pace();
  endtask

  // Largest register value and largest timestamp together: the deadline lands
  // above the timestamp range and must not wrap.
  task automatic test_register_extremes;
    set_min_frame(CFG_MAX);
    send_vsync(ts_t'(TS_MAX));
    send_vsync(ts_t'(TS_MAX));
    drain_pace();
    set_min_frame(cfg_word_t'(1_000_000));
    send_vsync(ts_t'(TS_MAX - 1));
    drain_pace();
  endtask

  // The receiver holds ready low for a long stretch while words keep coming,
  // so both stages fill and the vsync channel stalls.
  task automatic test_backpressure;
    set_min_frame(cfg_word_t'(33_000));
    sender_idles  = 1'b0;
    hold_off_left = 64;
    for (int i = 0; i < 16; i++) begin
      send_vsync(ts_t'(64'd1_000_000_000 + 64'(i) * 16_666_667));
    end
    drain_pace();
    sender_idles = 1'b1;
  endtask

  // Streams that look like real displays: a refresh period with jitter, dropped
  // vsyncs, and now and then a step back, a repeat, a zero or a wild timestamp.
  task automatic test_random_streams;
    int          period_ns;
    int          jitter;
    int          raw_cfg;
    int          pick;
    logic [63:0] stamp;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // One phase runs with no idling on either side.
      sender_idles   = (phase != 3);
      receiver_idles = (phase != 3);

      case ($urandom_range(9))
        0: period_ns = 16_666_667;
        1: period_ns = 8_333_333;
        2: period_ns = 6_944_444;
        3: period_ns = 4_166_667;
        4: period_ns = 11_111_111;
        5: period_ns = 33_333_333;
        6: period_ns = $urandom_range(4_000_001, 99_999_999);
        7: period_ns = $urandom_range(3_900_000, 4_100_000);
        8: period_ns = $urandom_range(95_000_000, 100_500_000);
        default: period_ns = 50_000_000;
      endcase
      jitter = period_ns / 100;

      // Register values cluster where pacing switches on and at whole multiples.
      case ($urandom_range(7))
        0: raw_cfg = 0;
        1: raw_cfg = int'(CFG_MAX);
        2: raw_cfg = 1_000_000;
        3: raw_cfg = (period_ns / 8 * 9) / 1000 + $urandom_range(4) - 2;
        4: raw_cfg = $urandom_range(1, 5_000);
        default: raw_cfg = (period_ns / 1000) * $urandom_range(1, 4)
                           + $urandom_range(2_000) - 1_000;
      endcase
      if (raw_cfg < 0) raw_cfg = 0;
      if (raw_cfg > int'(CFG_MAX)) raw_cfg = int'(CFG_MAX);
      set_min_frame(cfg_word_t'(raw_cfg));

      case ($urandom_range(2))
        0: stamp = 64'($urandom_range(1, 2_000_000_000));
        1: stamp = TS_MAX - 64'(PHASE_WORDS) * 64'd500_000_000;
        default: stamp = {$urandom, $urandom} & TS_MAX;
      endcase

      for (int n = 0; n < PHASE_WORDS; n++) begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          stamp = stamp + 64'(period_ns - jitter + $urandom_range(2 * jitter));
        end else if (pick < 88) begin
          stamp = stamp + 64'(period_ns) * $urandom_range(2, 4);
        end else if (pick < 92) begin
          if (stamp > 64'd10_000_000) begin
            stamp = stamp - 64'($urandom_range(1, 10_000_000));
          end
        end else if (pick < 94) begin
          // Same timestamp again.
        end else if (pick < 96) begin
          stamp = '0;
        end else begin
          stamp = {$urandom, $urandom} & TS_MAX;
        end
        if (stamp > TS_MAX) begin
          stamp = 64'($urandom_range(1, 2_000_000_000));
        end
        send_vsync(ts_t'(stamp));
      end
      drain_pace();
    end
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  // Predicts a pace word for every vsync word the block takes.
  always @(posedge clk) begin
    if (!rst && vsync_ch.valid && vsync_ch.ready) begin
      pending_pace.push_back(pace_decision(vsync_ch.vsync_time_ns));
      words_sent++;
    end
  end

  // Checks every pace word the block hands over against the oldest prediction.
  always @(posedge clk) begin : check_pace
    pace_word_t want;
    if (!rst && pace_ch.valid && pace_ch.ready) begin
      if (pending_pace.size() == 0) begin
        note_failure($sformatf("pace word with none owed: render_now %0b period %0d",
                               pace_ch.render_now, pace_ch.period_estimate_ns));
      end else begin
        want = pending_pace.pop_front();
        words_checked++;
        if (want.render_now == 1'b0) skips_seen++;
        if (pace_ch.render_now !== want.render_now) begin
          note_failure($sformatf("word %0d render_now: expected %0b, got %0b",
                                 words_checked, want.render_now, pace_ch.render_now));
        end
        if (pace_ch.period_estimate_ns !== want.period_estimate_ns) begin
          note_failure($sformatf("word %0d period_estimate_ns: expected %0d, got %0d",
                                 words_checked, want.period_estimate_ns,
                                 pace_ch.period_estimate_ns));
        end
      end
    end
  end

  // Receiver side: a hold-off stretch when one is requested, random stalls
  // otherwise, and none at all while receiver_idles is clear.
  initial begin
    pace_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        pace_ch.ready <= 1'b0;
        hold_off_left--;
      end else begin
        pace_ch.ready <= !(receiver_idles && $urandom_range(99) < 24);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** vsync_frame_pacer_unit: FAILED **");
    $finish;
  end

  // Main sequence: reset once, the directed tests, pressure, then random streams.
  initial begin
    rst                    <= 1'b1;
    vsync_ch.valid         <= 1'b0;
    vsync_ch.vsync_time_ns <= '0;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    last_stamp    = '0;
    period_est    = '0;
    deadline_ns   = '0;
    deadline_live = 1'b0;
    min_frame_us  = '0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    hold_off_left  = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_unknown_period_pacing();
    test_limit_threshold();
    test_delta_window();
    test_register_extremes();
    test_backpressure();
    test_random_streams();

    drain_pace();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_pace.size() != 0) begin
      note_failure($sformatf("%0d pace words never arrived", pending_pace.size()));
    end

    $display("Run covered %0d vsync words and %0d pace words (%0d skips) under %0d",
             words_sent, words_checked, skips_seen, settings_written);
    $display("register settings in %0d cycles; %0d failures", cycle_count, fail_count);
    if (fail_count == 0) begin
      $display("** vsync_frame_pacer_unit: PASSED **");
    end else begin
      $display("** vsync_frame_pacer_unit: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/vfp_pkg.sv
design/vfp_if.sv
design/vfp_cfg_regs.sv
design/vfp_core.sv
design/vsync_frame_pacer_unit.sv
design/vfp_checker.sv
tb/tb_top.sv
